>>> hw/rtl/dbpk_pkg.sv
// Shared types, codes and helper functions for the partial key lookup unit.
// Used by the interfaces, the mask accumulator, the rank walker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dbpk_pkg;

    localparam int MASK_BYTES_DEF  = 32;
    localparam int NUM_ENTRIES_DEF = 64;

    // Input operation codes.
    localparam logic [1:0] OP_MASK = 2'd0;
    localparam logic [1:0] OP_RANK = 2'd1;
    localparam logic [1:0] OP_KEY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] CFG_MASK_LENGTH = 2'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] index;
        logic [7:0] value;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  position;
        logic [63:0] partial_key;
    } t_out_word;

    typedef struct packed {
        logic [1:0] index;
        logic [6:0] data;
    } t_cfg_word;

    // Sequencer controls for the mask table and key accumulator.
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [6:0] rd_pos;
        logic [5:0] key_pos;
        logic [7:0] key_byte;
        logic       clr_acc;
        logic       clr_total;
    } t_mask_ctl;

    // Sequencer controls for the rank table and rank walk.
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       start;
        logic       ack;
        logic [6:0] entry_count;
    } t_rank_ctl;

    typedef struct packed {
        logic       done;
        logic [6:0] position;
    } t_rank_stat;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 8; b++) begin
            n = n + {3'd0, v[b]};
        end
        return n;
    endfunction

    // Packs the bits of v selected by m, lowest selected bit to bit 0.
    function automatic logic [7:0] pext8(input logic [7:0] v, input logic [7:0] m);
        logic [7:0] r;
        logic [3:0] k;
        r = '0;
        k = '0;
        for (int b = 0; b < 8; b++) begin
            if (m[b]) begin
                r[k[2:0]] = v[b];
                k = k + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dbpk_if.sv
// Valid/ready channel interfaces for input words, result words and configuration words.
// Depends on dbpk_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface dbpk_in_if;
    logic              valid;
    logic              ready;
    dbpk_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbpk_out_if;
    logic               valid;
    logic               ready;
    dbpk_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbpk_cfg_if;
    logic               valid;
    logic               ready;
    dbpk_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/disc_bit_partial_key_lookup_unit.sv
// Top level of the partial key lookup unit: sequencer, configuration registers
// and result register. Depends on dbpk_pkg, dbpk_if, dbpk_mask_acc, dbpk_rank_walk.
`timescale 1ns / 1ps
`default_nettype none

// Words enter on i_in one at a time; i_in.ready is high only while the sequencer
// is idle. A mask or rank load is written when it is accepted and leaves the
// sequencer idle. A key byte without last is accepted, then has its mask read and
// then absorbed when its position is covered by the masks; when it is not, no mask
// is read. A key byte with last sweeps every covered mask position through the
// single mask read port, one position a cycle, then walks the rank table through
// its single read port, reading and then evaluating each entry, skipped entries
// included, with the entry count capped at NUM_ENTRIES. Once the walk is done, the
// result is valid on o_out in the cycle after it is registered, and the next word
// can then be taken. The result is held in an output register, so loads may be
// taken while it waits on o_out; a later lookup holds at the end of its walk until
// that register is free. Configuration writes on i_cfg are always ready and must
// be made while the block is idle.
module disc_bit_partial_key_lookup_unit #(
    parameter int MASK_BYTES  = dbpk_pkg::MASK_BYTES_DEF,
    parameter int NUM_ENTRIES = dbpk_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dbpk_in_if.sink     i_in,
    dbpk_out_if.source  o_out,
    dbpk_cfg_if.sink    i_cfg
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [6:0]  r_entry_count;
    logic [5:0]  r_mask_length;
    logic [5:0]  r_kbp, n_kbp;
    logic [7:0]  r_key;
    logic        r_last;
    logic [6:0]  r_ptr, n_ptr;
    logic [6:0]  r_end, n_end;
    logic        r_ovalid;
    logic [6:0]  r_opos;
    logic [63:0] r_okey;

    dbpk_pkg::t_mask_ctl  mask_ctl;
    dbpk_pkg::t_rank_ctl  rank_ctl;
    dbpk_pkg::t_rank_stat rank_stat;
    logic [63:0]          acc;
    logic [8:0]           total;

    logic       in_acc;
    logic       cfg_acc;
    logic [6:0] cov_len;
    logic       sweep_rd;
    logic       out_free;
    logic       deliver;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign cov_len  = ({1'b0, r_mask_length} > 7'(MASK_BYTES)) ? 7'(MASK_BYTES)
                                                                : {1'b0, r_mask_length};
    assign sweep_rd = (r_state == S_SWEEP) && (r_ptr < r_end);
    assign out_free = !r_ovalid || o_out.ready;
    assign deliver  = (r_state == S_WALK) && rank_stat.done && out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_kbp   = r_kbp;
        n_ptr   = r_ptr;
        n_end   = r_end;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.data.op == dbpk_pkg::OP_KEY)) begin
                    n_state = S_SWEEP;
                    if (i_in.data.last) begin
                        // Sweep every covered position for the trailing bits and the total.
                        n_ptr = '0;
                        n_end = cov_len;
                    end else begin
                        n_ptr = {1'b0, r_kbp};
                        n_end = ({1'b0, r_kbp} < cov_len) ? {1'b0, r_kbp} + 7'd1
                                                          : {1'b0, r_kbp};
                    end
                end
            end
            S_SWEEP: begin
                if (sweep_rd) begin
                    n_ptr = r_ptr + 7'd1;
                end else if (r_last) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_IDLE;
                    if (r_kbp != 6'd63) begin
                        n_kbp = r_kbp + 6'd1;
                    end
                end
            end
            S_WALK: begin
                if (deliver) begin
                    n_state = S_IDLE;
                    n_kbp   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mask_ctl.wr_en     = in_acc && (i_in.data.op == dbpk_pkg::OP_MASK);
        mask_ctl.wr_addr   = i_in.data.index;
        mask_ctl.wr_data   = i_in.data.value;
        mask_ctl.rd_en     = sweep_rd;
        mask_ctl.rd_pos    = r_ptr;
        mask_ctl.key_pos   = r_kbp;
        mask_ctl.key_byte  = r_key;
        mask_ctl.clr_acc   = deliver;
        mask_ctl.clr_total = in_acc && (i_in.data.op == dbpk_pkg::OP_KEY) && i_in.data.last;

        rank_ctl.wr_en       = in_acc && (i_in.data.op == dbpk_pkg::OP_RANK);
        rank_ctl.wr_addr     = i_in.data.index;
        rank_ctl.wr_data     = i_in.data.value;
        rank_ctl.start       = (r_state == S_SWEEP) && !sweep_rd && r_last;
        rank_ctl.ack         = deliver;
        rank_ctl.entry_count = r_entry_count;
    end

    dbpk_mask_acc #(
        .MASK_BYTES (MASK_BYTES)
    ) u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mask_ctl),
        .o_acc   (acc),
        .o_total (total)
    );

    dbpk_rank_walk #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rank_ctl),
        .i_acc   (acc),
        .i_total (total),
        .o_stat  (rank_stat)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.data.op == dbpk_pkg::OP_KEY)) begin
            r_key  <= i_in.data.value;
            r_last <= i_in.data.last;
        end
        if (deliver) begin
            r_opos <= rank_stat.position;
            r_okey <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_mask_length <= '0;
            r_kbp         <= '0;
            r_ptr         <= '0;
            r_end         <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kbp   <= n_kbp;
            r_ptr   <= n_ptr;
            r_end   <= n_end;
            if (cfg_acc) begin
                case (i_cfg.data.index)
                    dbpk_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg.data.data;
                    dbpk_pkg::CFG_MASK_LENGTH: r_mask_length <= i_cfg.data.data[5:0];
                    default: begin
                    end
                endcase
            end
            if (deliver) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.data.position    = r_opos;
    assign o_out.data.partial_key = r_okey;

endmodule

`default_nettype wire

>>> hw/rtl/dbpk_mask_acc.sv
// Mask table memory with per-entry valid bits, the partial key accumulator
// and the running mask bit total. Depends on dbpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbpk_mask_acc #(
    parameter int MASK_BYTES = dbpk_pkg::MASK_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dbpk_pkg::t_mask_ctl i_ctl,
    output logic [63:0]              o_acc,
    output logic [8:0]               o_total
);

    localparam int MA = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;

    logic [7:0]            r_mem [MASK_BYTES];
    logic [MASK_BYTES-1:0] r_mvalid;
    logic [7:0]            r_q;
    logic                  r_qv;
    logic [6:0]            r_qpos;
    logic                  r_qen;
    logic [63:0]           r_acc, n_acc;
    logic [8:0]            r_total, n_total;

    logic [7:0] mask;
    logic [3:0] pc;
    logic [7:0] bits;
    logic       wr_ok;

    assign wr_ok = i_ctl.wr_en && ({1'b0, i_ctl.wr_addr} < 7'(MASK_BYTES));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_ctl.wr_addr[MA-1:0]] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q    <= r_mem[i_ctl.rd_pos[MA-1:0]];
            r_qv   <= r_mvalid[i_ctl.rd_pos[MA-1:0]];
            r_qpos <= i_ctl.rd_pos;
        end
    end

    // An entry that was never loaded reads as a zero mask.
    always_comb begin
        mask = r_qv ? r_q : 8'd0;
        pc   = dbpk_pkg::popcount8(mask);
        bits = (r_qpos == {1'b0, i_ctl.key_pos}) ? dbpk_pkg::pext8(i_ctl.key_byte, mask)
                                                  : 8'd0;
        n_acc   = r_acc;
        n_total = r_total;
        if (r_qen) begin
            n_total = r_total + {5'd0, pc};
            // Positions before the current key byte were absorbed earlier.
            if (r_qpos >= {1'b0, i_ctl.key_pos}) begin
                n_acc = (r_acc << pc) | {56'd0, bits};
            end
        end
        if (i_ctl.clr_acc) begin
            n_acc = '0;
        end
        if (i_ctl.clr_total) begin
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
            r_qen    <= 1'b0;
            r_acc    <= '0;
            r_total  <= '0;
        end else begin
            if (wr_ok) begin
                r_mvalid[i_ctl.wr_addr[MA-1:0]] <= 1'b1;
            end
            r_qen   <= i_ctl.rd_en;
            r_acc   <= n_acc;
            r_total <= n_total;
        end
    end

    assign o_acc   = r_acc;
    assign o_total = r_total;

endmodule

`default_nettype wire

>>> hw/rtl/dbpk_rank_walk.sv
// Rank table memory and the rank walk that finds the entry position of a key.
// Depends on dbpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbpk_rank_walk #(
    parameter int NUM_ENTRIES = dbpk_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dbpk_pkg::t_rank_ctl  i_ctl,
    input  wire logic [63:0]          i_acc,
    input  wire logic [8:0]           i_total,
    output dbpk_pkg::t_rank_stat      o_stat
);

    localparam int RA = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IW = $clog2(NUM_ENTRIES + 1);

    logic [7:0]    r_mem [NUM_ENTRIES];
    logic [7:0]    r_q;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_pos, n_pos;
    logic          r_skip, n_skip;
    logic [7:0]    r_thr, n_thr;
    logic          r_run, n_run;
    logic          r_eval, n_eval;

    logic [8:0]    n9;
    logic [IW-1:0] count;
    logic [8:0]    bit_idx;
    logic          key_bit;
    logic          wr_ok;

    assign wr_ok = i_ctl.wr_en && ({3'd0, i_ctl.wr_addr} < 9'(NUM_ENTRIES));
    assign n9    = ({2'd0, i_ctl.entry_count} > 9'(NUM_ENTRIES)) ? 9'(NUM_ENTRIES)
                                                                  : {2'd0, i_ctl.entry_count};
    assign count = IW'(n9);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[RA'(i_ctl.wr_addr)] <= i_ctl.wr_data;
        end
        if (r_run && !r_eval && (r_i < count)) begin
            r_q <= r_mem[r_i[RA-1:0]];
        end
    end

    // Bit of the partial key that the rank points at; out of range reads as clear.
    always_comb begin
        bit_idx = i_total - 9'd1 - {1'b0, r_q};
        key_bit = 1'b0;
        if (({1'b0, r_q} < i_total) && (bit_idx < 9'd64)) begin
            key_bit = i_acc[bit_idx[5:0]];
        end
    end

    always_comb begin
        n_i    = r_i;
        n_pos  = r_pos;
        n_skip = r_skip;
        n_thr  = r_thr;
        n_run  = r_run;
        n_eval = r_eval;
        if (i_ctl.start) begin
            n_i    = '0;
            n_pos  = '0;
            n_skip = 1'b0;
            n_run  = 1'b1;
            n_eval = 1'b0;
        end else if (i_ctl.ack) begin
            n_run = 1'b0;
        end else if (r_run) begin
            if (!r_eval) begin
                n_eval = (r_i < count);
            end else begin
                // Every evaluated entry advances the index by one.
                n_i    = r_i + IW'(1);
                n_eval = 1'b0;
                if (!(r_skip && (r_q >= r_thr))) begin
                    if (key_bit) begin
                        n_pos  = r_i + IW'(1);
                        n_skip = 1'b0;
                    end else begin
                        n_thr  = r_q;
                        n_skip = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_pos  <= '0;
            r_skip <= 1'b0;
            r_thr  <= '0;
            r_run  <= 1'b0;
            r_eval <= 1'b0;
        end else begin
            r_i    <= n_i;
            r_pos  <= n_pos;
            r_skip <= n_skip;
            r_thr  <= n_thr;
            r_run  <= n_run;
            r_eval <= n_eval;
        end
    end

    assign o_stat.done     = r_run && !r_eval && (r_i >= count);
    assign o_stat.position = 7'(r_pos);

endmodule

`default_nettype wire
